FILE: sv/rotating_frame_inertial_force_core_assert.svh
// assertion macros for the rotating frame inertial force core
`ifndef ROTATING_FRAME_INERTIAL_FORCE_CORE_ASSERT_SVH
`define ROTATING_FRAME_INERTIAL_FORCE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// implication checked on every rising clock edge outside reset
`define RFIF_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define RFIF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RFIF_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define RFIF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: sv/rfif_pkg.sv
// shared types, constants and fixed-point helpers for the inertial force core
package rfif_pkg;

    localparam int unsigned REG_W     = 48;
    localparam int unsigned CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ACCEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_OMEGA = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ALPHA = 3'd5;

    // reset values: identity rotation, zero frame vectors
    localparam logic [REG_W-1:0] ROT_ROW0_RST = 48'h0000_0000_4000;
    localparam logic [REG_W-1:0] ROT_ROW1_RST = 48'h0000_4000_0000;
    localparam logic [REG_W-1:0] ROT_ROW2_RST = 48'h4000_0000_0000;

    // internal widths
    localparam int unsigned XO_W  = 36;  // rotated position / velocity, Q.16
    localparam int unsigned CP_W  = 52;  // 16 x 36 products
    localparam int unsigned CD_W  = 53;  // cross differences, Q.24
    localparam int unsigned W_W   = 45;  // omega x xo rounded to Q.16
    localparam int unsigned T2P_W = 61;  // 16 x 45 products
    localparam int unsigned S_W   = 46;  // saturated sum and back rotation
    localparam int unsigned BP_W  = 62;  // 16 x 46 products
    localparam int unsigned MP_W  = 63;  // 46 x 17 mass products

    // cross product operand order
    localparam logic [1:0] CRS_A [3] = '{2'd1, 2'd2, 2'd0};
    localparam logic [1:0] CRS_B [3] = '{2'd2, 2'd0, 2'd1};

    typedef logic signed [15:0] coef_t;

    typedef struct packed {
        logic        last_in;
        logic [15:0] point_mass;
        logic [31:0] vel_z;
        logic [31:0] vel_y;
        logic [31:0] vel_x;
        logic [31:0] pos_z;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } rfif_in_t;

    typedef struct packed {
        logic        last_out;
        logic [31:0] force_z;
        logic [31:0] force_y;
        logic [31:0] force_x;
    } rfif_out_t;

    // control and sideband that travel with each point
    typedef struct packed {
        logic        valid;
        logic        last;
        logic [15:0] mass;
    } rfif_side_t;

    function automatic coef_t lane16(input logic [REG_W-1:0] word, input logic [1:0] idx);
        coef_t res;
        case (idx)
            2'd0:    res = word[15:0];
            2'd1:    res = word[31:16];
            2'd2:    res = word[47:32];
            default: res = '0;
        endcase
        return res;
    endfunction

    // add half lsb, then arithmetic shift (floor)
    function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                   input logic [5:0] k);
        logic signed [63:0] half;
        half = 64'sd1 <<< (k - 6'd1);
        return (v + half) >>> k;
    endfunction

    function automatic logic signed [S_W-1:0] sat46(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd35184372088831;
        lo = -64'sd35184372088832;
        if (v > hi) begin
            return hi[S_W-1:0];
        end else if (v < lo) begin
            return lo[S_W-1:0];
        end
        return v[S_W-1:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi) begin
            return hi[31:0];
        end else if (v < lo) begin
            return lo[31:0];
        end
        return v[31:0];
    endfunction

endpackage

FILE: sv/rfif_frame_rot.sv
// forward rotation of position and velocity into frame axes, two stages
module rfif_frame_rot import rfif_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  rfif_side_t             side_in,
    input  rfif_in_t               item_in,
    input  coef_t                  rm [3][3],
    output rfif_side_t             side_out,
    output logic signed [XO_W-1:0] xo [3],
    output logic signed [XO_W-1:0] vo [3]
);

    logic signed [31:0] px [3];
    logic signed [31:0] pv [3];
    logic signed [47:0] prod_x_reg [3][3];
    logic signed [47:0] prod_v_reg [3][3];
    logic signed [XO_W-1:0] xo_reg [3];
    logic signed [XO_W-1:0] vo_reg [3];
    logic signed [XO_W-1:0] xo_next [3];
    logic signed [XO_W-1:0] vo_next [3];
    rfif_side_t side1_reg;
    rfif_side_t side2_reg;

    assign px[0] = item_in.pos_x;
    assign px[1] = item_in.pos_y;
    assign px[2] = item_in.pos_z;
    assign pv[0] = item_in.vel_x;
    assign pv[1] = item_in.vel_y;
    assign pv[2] = item_in.vel_z;

    // valid and sideband
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side1_reg <= '0;
            side2_reg <= '0;
        end else if (en) begin
            side1_reg <= side_in;
            side2_reg <= side1_reg;
        end
    end

    // stage 1: matrix entry products
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod_x_reg[r][c] <= 48'(rm[r][c]) * 48'(px[c]);
                    prod_v_reg[r][c] <= 48'(rm[r][c]) * 48'(pv[c]);
                end
            end
        end
    end

    // stage 2: row sums rounded from Q.30 to Q.16
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            xo_next[r] = XO_W'(rnd_shr(64'(prod_x_reg[r][0]) + 64'(prod_x_reg[r][1])
                                       + 64'(prod_x_reg[r][2]), 6'd14));
            vo_next[r] = XO_W'(rnd_shr(64'(prod_v_reg[r][0]) + 64'(prod_v_reg[r][1])
                                       + 64'(prod_v_reg[r][2]), 6'd14));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xo_reg <= xo_next;
            vo_reg <= vo_next;
        end
    end

    assign xo       = xo_reg;
    assign vo       = vo_reg;
    assign side_out = side2_reg;

endmodule

FILE: sv/rfif_fict_sum.sv
// angular, centrifugal and coriolis terms plus frame acceleration, four stages
module rfif_fict_sum import rfif_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  rfif_side_t            side_in,
    input  logic signed [XO_W-1:0] xo [3],
    input  logic signed [XO_W-1:0] vo [3],
    input  coef_t                 om [3],
    input  coef_t                 al [3],
    input  coef_t                 acc [3],
    output rfif_side_t            side_out,
    output logic signed [S_W-1:0] s [3]
);

    logic signed [CP_W-1:0]  wp_reg [3];
    logic signed [CP_W-1:0]  wn_reg [3];
    logic signed [CP_W-1:0]  t1p_reg [3];
    logic signed [CP_W-1:0]  t1n_reg [3];
    logic signed [CP_W-1:0]  t3p_reg [3];
    logic signed [CP_W-1:0]  t3n_reg [3];
    logic signed [W_W-1:0]   w_reg [3];
    logic signed [CD_W-1:0]  t1_reg [3];
    logic signed [CD_W-1:0]  t3_reg [3];
    logic signed [T2P_W-1:0] t2p_reg [3];
    logic signed [T2P_W-1:0] t2n_reg [3];
    logic signed [CD_W-1:0]  t1d_reg [3];
    logic signed [CD_W-1:0]  t3d_reg [3];
    logic signed [S_W-1:0]   s_reg [3];
    logic signed [S_W-1:0]   s_next [3];
    rfif_side_t side3_reg;
    rfif_side_t side4_reg;
    rfif_side_t side5_reg;
    rfif_side_t side6_reg;

    // valid and sideband
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side3_reg <= '0;
            side4_reg <= '0;
            side5_reg <= '0;
            side6_reg <= '0;
        end else if (en) begin
            side3_reg <= side_in;
            side4_reg <= side3_reg;
            side5_reg <= side4_reg;
            side6_reg <= side5_reg;
        end
    end

    // stage 3: cross product terms of omega and alpha with xo, omega with vo
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                wp_reg[k]  <= CP_W'(om[CRS_A[k]]) * CP_W'(xo[CRS_B[k]]);
                wn_reg[k]  <= CP_W'(om[CRS_B[k]]) * CP_W'(xo[CRS_A[k]]);
                t1p_reg[k] <= CP_W'(al[CRS_A[k]]) * CP_W'(xo[CRS_B[k]]);
                t1n_reg[k] <= CP_W'(al[CRS_B[k]]) * CP_W'(xo[CRS_A[k]]);
                t3p_reg[k] <= CP_W'(om[CRS_A[k]]) * CP_W'(vo[CRS_B[k]]);
                t3n_reg[k] <= CP_W'(om[CRS_B[k]]) * CP_W'(vo[CRS_A[k]]);
            end
        end
    end

    // stage 4: differences, omega x xo rounded to Q.16
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                w_reg[k]  <= W_W'(rnd_shr(64'(wp_reg[k]) - 64'(wn_reg[k]), 6'd8));
                t1_reg[k] <= CD_W'(t1p_reg[k]) - CD_W'(t1n_reg[k]);
                t3_reg[k] <= CD_W'(t3p_reg[k]) - CD_W'(t3n_reg[k]);
            end
        end
    end

    // stage 5: centrifugal products omega x w
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                t2p_reg[k] <= T2P_W'(om[CRS_A[k]]) * T2P_W'(w_reg[CRS_B[k]]);
                t2n_reg[k] <= T2P_W'(om[CRS_B[k]]) * T2P_W'(w_reg[CRS_A[k]]);
            end
            t1d_reg <= t1_reg;
            t3d_reg <= t3_reg;
        end
    end

    // stage 6: Q.24 total, rounded to Q.16 and saturated
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s_next[k] = sat46(rnd_shr(64'(t2p_reg[k]) - 64'(t2n_reg[k]) + 64'(t1d_reg[k])
                                      + (64'(t3d_reg[k]) <<< 1) + (64'(acc[k]) <<< 16),
                                      6'd8));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg <= s_next;
        end
    end

    assign s        = s_reg;
    assign side_out = side6_reg;

endmodule

FILE: sv/rfif_back_rot.sv
// transposed rotation back to local axes, two stages
module rfif_back_rot import rfif_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  rfif_side_t            side_in,
    input  logic signed [S_W-1:0] s [3],
    input  coef_t                 rm [3][3],
    output rfif_side_t            side_out,
    output logic signed [S_W-1:0] f [3]
);

    logic signed [BP_W-1:0] bp_reg [3][3];
    logic signed [S_W-1:0]  f_reg [3];
    logic signed [S_W-1:0]  f_next [3];
    rfif_side_t side7_reg;
    rfif_side_t side8_reg;

    // valid and sideband
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side7_reg <= '0;
            side8_reg <= '0;
        end else if (en) begin
            side7_reg <= side_in;
            side8_reg <= side7_reg;
        end
    end

    // stage 7: entry products
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    bp_reg[r][c] <= BP_W'(rm[r][c]) * BP_W'(s[r]);
                end
            end
        end
    end

    // stage 8: column sums rounded from Q.30 and saturated
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            f_next[c] = sat46(rnd_shr(64'(bp_reg[0][c]) + 64'(bp_reg[1][c])
                                      + 64'(bp_reg[2][c]), 6'd14));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_reg <= f_next;
        end
    end

    assign f        = f_reg;
    assign side_out = side8_reg;

endmodule

FILE: sv/rfif_mass_scale.sv
// scale by minus the mass and saturate to the output format, two stages
module rfif_mass_scale import rfif_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  rfif_side_t            side_in,
    input  logic signed [S_W-1:0] f [3],
    output rfif_side_t            side_out,
    output rfif_out_t             item_out
);

    logic signed [MP_W-1:0] mp_reg [3];
    logic signed [31:0]     frc_next [3];
    rfif_out_t  out_reg;
    rfif_side_t side9_reg;
    rfif_side_t side10_reg;

    // valid and sideband
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side9_reg  <= '0;
            side10_reg <= '0;
        end else if (en) begin
            side9_reg  <= side_in;
            side10_reg <= side9_reg;
        end
    end

    // stage 9: mass products
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                mp_reg[c] <= MP_W'(f[c]) * MP_W'($signed({1'b0, side_in.mass}));
            end
        end
    end

    // stage 10: negate, round to Q.16, saturate
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            frc_next[c] = sat32(rnd_shr(-64'(mp_reg[c]), 6'd8));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.force_x  <= frc_next[0];
            out_reg.force_y  <= frc_next[1];
            out_reg.force_z  <= frc_next[2];
            out_reg.last_out <= side9_reg.last;
        end
    end

    assign item_out = out_reg;
    assign side_out = side10_reg;

endmodule

FILE: sv/rotating_frame_inertial_force_core.sv
// Inertial force core: one point is taken per clock cycle while the pipe
// is not held, and its force vector is produced by two stages of forward
// rotation, four of cross-product terms, two of back rotation and two of
// mass scaling. The ten stages advance together: the whole pipe holds only
// while a result sits on the output register and m_ready is low, so
// s_ready follows that condition. Configuration writes are always taken
// and must only be issued while no point is in flight.
`include "rotating_frame_inertial_force_core_assert.svh"

module rotating_frame_inertial_force_core import rfif_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rfif_in_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rfif_out_t            m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data
);

    logic [REG_W-1:0] rot0_reg;
    logic [REG_W-1:0] rot1_reg;
    logic [REG_W-1:0] rot2_reg;
    logic [REG_W-1:0] accel_reg;
    logic [REG_W-1:0] omega_reg;
    logic [REG_W-1:0] alpha_reg;
    coef_t rm [3][3];
    coef_t om [3];
    coef_t al [3];
    coef_t acc [3];
    logic en;
    rfif_side_t side_in;
    rfif_side_t side_rot;
    rfif_side_t side_sum;
    rfif_side_t side_back;
    rfif_side_t side_out;
    logic signed [XO_W-1:0] xo [3];
    logic signed [XO_W-1:0] vo [3];
    logic signed [S_W-1:0]  s [3];
    logic signed [S_W-1:0]  f [3];

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot0_reg  <= ROT_ROW0_RST;
            rot1_reg  <= ROT_ROW1_RST;
            rot2_reg  <= ROT_ROW2_RST;
            accel_reg <= '0;
            omega_reg <= '0;
            alpha_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ROT_ROW0:    rot0_reg  <= cfg_data;
                REG_ROT_ROW1:    rot1_reg  <= cfg_data;
                REG_ROT_ROW2:    rot2_reg  <= cfg_data;
                REG_FRAME_ACCEL: accel_reg <= cfg_data;
                REG_FRAME_OMEGA: omega_reg <= cfg_data;
                REG_FRAME_ALPHA: alpha_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // unpack register lanes
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rm[0][k] = lane16(rot0_reg, 2'(k));
            rm[1][k] = lane16(rot1_reg, 2'(k));
            rm[2][k] = lane16(rot2_reg, 2'(k));
            acc[k]   = lane16(accel_reg, 2'(k));
            om[k]    = lane16(omega_reg, 2'(k));
            al[k]    = lane16(alpha_reg, 2'(k));
        end
    end

    // global pipe advance
    assign en      = !side_out.valid || m_ready;
    assign s_ready = en;

    assign side_in.valid = s_valid;
    assign side_in.last  = s_data.last_in;
    assign side_in.mass  = s_data.point_mass;

    rfif_frame_rot u_frame_rot (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .side_in  (side_in),
        .item_in  (s_data),
        .rm       (rm),
        .side_out (side_rot),
        .xo       (xo),
        .vo       (vo)
    );

    rfif_fict_sum u_fict_sum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .side_in  (side_rot),
        .xo       (xo),
        .vo       (vo),
        .om       (om),
        .al       (al),
        .acc      (acc),
        .side_out (side_sum),
        .s        (s)
    );

    rfif_back_rot u_back_rot (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .side_in  (side_sum),
        .s        (s),
        .rm       (rm),
        .side_out (side_back),
        .f        (f)
    );

    rfif_mass_scale u_mass_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .side_in  (side_back),
        .f        (f),
        .side_out (side_out),
        .item_out (m_data)
    );

    assign m_valid = side_out.valid;

    // checks
    `RFIF_ASSERT_IMPL(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready, "pipe stalled with empty output")
    `RFIF_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, side_rot.valid || !u_frame_rot.side1_reg.valid == 1'b0, "accepted point lost")
    `RFIF_ASSERT_IMPL(a_zero_mass, aclk, aresetn, m_valid && (side_out.mass == 16'd0), (m_data.force_x == 32'd0) && (m_data.force_y == 32'd0) && (m_data.force_z == 32'd0), "zero mass gave nonzero force")

endmodule
